FILE: hdl/bepd_pkg.sv
// ---------------------------------------------------------------------------
// bepd_pkg
// Shared types, register codes and constants of the band envelope peak
// detector.
// ---------------------------------------------------------------------------
package bepd_pkg;

    localparam int NUM_BANDS_DEF = 12;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        CFG_ACTIVE_BANDS    = 3'd0,
        CFG_AMP_GAIN        = 3'd1,
        CFG_ATTACK_GAIN     = 3'd2,
        CFG_RELEASE_GAIN    = 3'd3,
        CFG_DELTA_THRESHOLD = 3'd4,
        CFG_RISE_THRESHOLD  = 3'd5,
        CFG_LEVEL_FLOOR     = 3'd6,
        CFG_REFRACTORY      = 3'd7
    } t_cfg_idx;

    // register reset values
    localparam logic [3:0]  RST_ACTIVE_BANDS    = 4'd12;
    localparam logic [15:0] RST_AMP_GAIN        = 16'd5243;
    localparam logic [15:0] RST_ATTACK_GAIN     = 16'd22938;
    localparam logic [15:0] RST_RELEASE_GAIN    = 16'd5243;
    localparam logic [7:0]  RST_DELTA_THRESHOLD = 8'd38;
    localparam logic [15:0] RST_RISE_THRESHOLD  = 16'd5243;
    localparam logic [15:0] RST_LEVEL_FLOOR     = 16'd11796;
    localparam logic [2:0]  RST_REFRACTORY      = 3'd5;

    // shade mapping
    localparam logic [7:0] SHADE_MULT  = 8'd180;
    localparam logic [7:0] SHADE_BASE  = 8'd200;
    localparam logic [7:0] SHADE_MIN   = 8'd30;
    localparam logic [7:0] SHADE_MAX   = 8'd230;
    localparam logic [7:0] DARK_LIMIT  = 8'd170;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_GAIN,
        ST_UPD,
        ST_DARK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic gain;
        logic upd;
        logic dark;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

FILE: hdl/bepd_ctrl.sv
// ---------------------------------------------------------------------------
// bepd_ctrl
// Sequencer: steps one band beat through the datapath stages.
// ---------------------------------------------------------------------------
module bepd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  bepd_pkg::t_status i_status,
    output bepd_pkg::t_cmd    o_cmd
);

    bepd_pkg::t_state r_state;
    bepd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bepd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            bepd_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = bepd_pkg::ST_MUL;
                end
            end
            bepd_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = bepd_pkg::ST_GAIN;
            end
            bepd_pkg::ST_GAIN: begin
                o_cmd.gain = 1'b1;
                n_state    = bepd_pkg::ST_UPD;
            end
            bepd_pkg::ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = bepd_pkg::ST_DARK;
            end
            bepd_pkg::ST_DARK: begin
                o_cmd.dark = 1'b1;
                n_state    = bepd_pkg::ST_DONE;
            end
            bepd_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = bepd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bepd_pkg::ST_IDLE;
            end
        endcase
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == bepd_pkg::ST_MUL))
        else $error("accepted beat did not start the multiply step");

    a_load_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> (r_state == bepd_pkg::ST_IDLE))
        else $error("result load did not return to idle");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command at once");

endmodule

FILE: hdl/bepd_dp.sv
// ---------------------------------------------------------------------------
// bepd_dp
// Datapath: config registers, per-band state, envelope math and result reg.
// ---------------------------------------------------------------------------
module bepd_dp #(
    parameter int NUM_BANDS = bepd_pkg::NUM_BANDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    // input beat fields
    input  logic              i_restart,
    input  logic [3:0]        i_band_index,
    input  logic [15:0]       i_amplitude,
    input  logic [7:0]        i_band_delta,
    input  logic              i_delta_fresh,
    // control
    input  bepd_pkg::t_cmd    i_cmd,
    output bepd_pkg::t_status o_status,
    // result
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output logic [3:0]        o_band_out,
    output logic [15:0]       o_band_energy,
    output logic              o_peak,
    output logic [7:0]        o_shade
);

    localparam int BW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int IW = (BW > 4) ? BW : 4;
    localparam logic [5:0] NB = 6'(NUM_BANDS);

    // config registers
    logic [3:0]  r_active;
    logic [15:0] r_amp_gain;
    logic [15:0] r_attack;
    logic [15:0] r_release;
    logic [7:0]  r_dthr;
    logic [15:0] r_rise;
    logic [15:0] r_floor;
    logic [2:0]  r_refr;

    // band state
    logic [15:0] r_energy [NUM_BANDS];
    logic [2:0]  r_cool   [NUM_BANDS];

    // beat under work
    logic [3:0]  r_band;
    logic [15:0] r_amp;
    logic [7:0]  r_delta;
    logic        r_fresh;
    logic [31:0] r_prod1;
    logic [31:0] r_prod2;
    logic        r_up;
    logic [15:0] r_prev;
    logic [15:0] r_e;
    logic        r_pk;
    logic [7:0]  r_dark;

    // result register
    logic        r_o_valid;
    logic [3:0]  r_o_band;
    logic [15:0] r_o_energy;
    logic        r_o_peak;
    logic [7:0]  r_o_shade;

    logic [IW-1:0] band_w;
    logic [BW-1:0] idx;
    logic [5:0]    band6;
    logic [5:0]    bands6;
    logic          oob;
    logic          in_active;
    logic [15:0]   amp_eff;
    logic [15:0]   target;
    logic          up;
    logic [15:0]   diff;
    logic [15:0]   step;
    logic [15:0]   n_e;
    logic [2:0]    cd_dec;
    logic          cond;
    logic          n_pk;
    logic [2:0]    n_cd;
    logic [23:0]   dark_prod;
    logic [7:0]    shade;

    assign band_w    = IW'(r_band);
    assign idx       = band_w[BW-1:0];
    assign band6     = {2'b00, r_band};
    assign bands6    = (r_active != 4'd0) ? {2'b00, r_active} : NB;
    assign oob       = (band6 >= NB);
    assign in_active = (band6 < bands6);
    assign amp_eff   = in_active ? r_amp : 16'd0;

    // target saturates at 1.0
    assign target = (r_prod1[31:24] != 8'd0) ? 16'hFFFF : r_prod1[23:8];
    assign up     = (target > r_prev);
    assign diff   = up ? (target - r_prev) : (r_prev - target);

    assign step   = r_prod2[31:16];
    assign n_e    = oob ? 16'd0 : (r_up ? (r_prev + step) : (r_prev - step));

    assign cd_dec = (oob || r_cool[idx] == 3'd0) ? 3'd0 : (r_cool[idx] - 3'd1);
    assign cond   = r_fresh ? (r_delta > r_dthr)
                            : ((n_e > r_prev) && ((n_e - r_prev) > r_rise) &&
                               (n_e > r_floor));
    assign n_pk   = !oob && cond && (cd_dec == 3'd0);
    assign n_cd   = n_pk ? r_refr : cd_dec;

    assign dark_prod = r_e * bepd_pkg::SHADE_MULT;
    assign shade     = (r_dark >= bepd_pkg::DARK_LIMIT) ? bepd_pkg::SHADE_MIN
                                                         : (bepd_pkg::SHADE_BASE - r_dark);

    assign o_status.out_free = !r_o_valid || i_m_tready;

    // config and band state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= bepd_pkg::RST_ACTIVE_BANDS;
            r_amp_gain  <= bepd_pkg::RST_AMP_GAIN;
            r_attack    <= bepd_pkg::RST_ATTACK_GAIN;
            r_release   <= bepd_pkg::RST_RELEASE_GAIN;
            r_dthr      <= bepd_pkg::RST_DELTA_THRESHOLD;
            r_rise      <= bepd_pkg::RST_RISE_THRESHOLD;
            r_floor     <= bepd_pkg::RST_LEVEL_FLOOR;
            r_refr      <= bepd_pkg::RST_REFRACTORY;
            for (int i = 0; i < NUM_BANDS; i++) begin
                r_energy[i] <= 16'd0;
                r_cool[i]   <= 3'd0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (bepd_pkg::t_cfg_idx'(i_cfg_index))
                    bepd_pkg::CFG_ACTIVE_BANDS:    r_active    <= i_cfg_data[3:0];
                    bepd_pkg::CFG_AMP_GAIN:        r_amp_gain  <= i_cfg_data;
                    bepd_pkg::CFG_ATTACK_GAIN:     r_attack    <= i_cfg_data;
                    bepd_pkg::CFG_RELEASE_GAIN:    r_release   <= i_cfg_data;
                    bepd_pkg::CFG_DELTA_THRESHOLD: r_dthr      <= i_cfg_data[7:0];
                    bepd_pkg::CFG_RISE_THRESHOLD:  r_rise      <= i_cfg_data;
                    bepd_pkg::CFG_LEVEL_FLOOR:     r_floor     <= i_cfg_data;
                    bepd_pkg::CFG_REFRACTORY:      r_refr      <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_in && i_restart) begin
                for (int i = 0; i < NUM_BANDS; i++) begin
                    r_energy[i] <= 16'd0;
                    r_cool[i]   <= 3'd0;
                end
            end else if (i_cmd.upd && !oob) begin
                r_energy[idx] <= n_e;
                r_cool[idx]   <= n_cd;
            end
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_band  <= i_band_index;
            r_amp   <= i_amplitude;
            r_delta <= i_band_delta;
            r_fresh <= i_delta_fresh;
        end
        if (i_cmd.mul) begin
            r_prod1 <= amp_eff * r_amp_gain;
            r_prev  <= oob ? 16'd0 : r_energy[idx];
        end
        if (i_cmd.gain) begin
            r_prod2 <= diff * (up ? r_attack : r_release);
            r_up    <= up;
        end
        if (i_cmd.upd) begin
            r_e  <= n_e;
            r_pk <= n_pk;
        end
        if (i_cmd.dark) begin
            r_dark <= dark_prod[23:16];
        end
        if (i_cmd.load_out) begin
            r_o_band   <= r_band;
            r_o_energy <= r_e;
            r_o_peak   <= r_pk;
            r_o_shade  <= shade;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_m_tvalid    = r_o_valid;
    assign o_band_out    = r_o_band;
    assign o_band_energy = r_o_energy;
    assign o_peak        = r_o_peak;
    assign o_shade       = r_o_shade;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_o_valid || i_m_tready))
        else $error("result register overwritten while held");

    a_shade_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_shade >= bepd_pkg::SHADE_MIN &&
                       r_o_shade <= bepd_pkg::SHADE_MAX))
        else $error("shade out of range");

    a_oob_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && ({2'b00, r_o_band} >= NB)) |->
            (!r_o_peak && r_o_energy == 16'd0))
        else $error("out of range band gave energy or peak");

endmodule

FILE: hdl/band_envelope_peak_detector_core.sv
// ---------------------------------------------------------------------------
// band_envelope_peak_detector_core
// Per-band attack/release envelope follower with refractory peak detect.
// ---------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s         in   i_s_tvalid / o_s_tready   tdata: band_index, amplitude, band_delta
//                                           tuser: restart, delta_fresh
//  m         out  o_m_tvalid / i_m_tready   tdata: band_out, band_energy, shade
//                                           tuser: peak
//  cfg       in   i_cfg_valid / o_cfg_ready index 0..7, 16-bit data
//
//  A beat runs through these steps, from accept to the next accept: accept,
//  scale multiply, gain multiply, energy/peak update, shade multiply, result
//  load. The two chained multiplies plus the shade multiply are each registered.
//  Result sits in an output register; a stalled m side holds the sequencer
//  in its last step until the result register frees up.
//  Reset (i_rst_n low, synchronous) clears all band state at once and loads
//  the register defaults. Config writes are always ready.
// ---------------------------------------------------------------------------
module band_envelope_peak_detector_core #(
    parameter int NUM_BANDS = bepd_pkg::NUM_BANDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [3:0] band_index, [19:4] amplitude,
                                     // [27:20] band_delta, [31:28] zero
    input  logic [1:0]  i_s_tuser,   // [0] restart, [1] delta_fresh
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [3:0] band_out, [19:4] band_energy,
                                     // [27:20] shade, [31:28] zero
    output logic [0:0]  o_m_tuser,   // [0] peak
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    bepd_pkg::t_cmd    cmd;
    bepd_pkg::t_status status;

    logic [3:0]  band_out;
    logic [15:0] band_energy;
    logic        peak;
    logic [7:0]  shade;

    // config is taken any cycle; only written while idle by contract
    assign o_cfg_ready = 1'b1;

    bepd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bepd_dp #(
        .NUM_BANDS (NUM_BANDS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_restart     (i_s_tuser[0]),
        .i_band_index  (i_s_tdata[3:0]),
        .i_amplitude   (i_s_tdata[19:4]),
        .i_band_delta  (i_s_tdata[27:20]),
        .i_delta_fresh (i_s_tuser[1]),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_band_out    (band_out),
        .o_band_energy (band_energy),
        .o_peak        (peak),
        .o_shade       (shade)
    );

    // pack result beat, low field first
    assign o_m_tdata = {4'd0, shade, band_energy, band_out};
    assign o_m_tuser = peak;

endmodule

FILE: tb/tb_band_envelope_peak_detector_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_band_envelope_peak_detector_core
// Self-checking bench for the band envelope peak detector. A bit-exact
// envelope/peak predictor tracks every band, the result stream is checked
// beat by beat, and the run sweeps register settings under random idling.
// ---------------------------------------------------------------------------
module tb_band_envelope_peak_detector_core;

    localparam int N_BANDS     = bepd_pkg::NUM_BANDS_DEF;
    localparam int HOLD_CYCLES = 300;    // long m-side stall, fills the core
    localparam int STALL_LIMIT = 3000;   // cycles without any beat -> timeout
    localparam int TAIL_CYCLES = 20;     // quiet time after the last result
    localparam int PHASE_ITEMS = 100;
    localparam int N_PHASES    = 6;

    // one result beat, field order matches the concatenation in the monitor
    typedef struct packed {
        logic [3:0]  band;
        logic [15:0] energy;
        logic        peak;
        logic [7:0]  shade;
    } t_band_result;

    // -----------------------------------------------------------------------
    // Envelope predictor plus result queue
    // -----------------------------------------------------------------------
    class band_scoreboard;
        logic [15:0]  energy_mem [N_BANDS];
        logic [2:0]   cool_mem   [N_BANDS];
        logic [3:0]   active_bands;
        logic [15:0]  amp_gain;
        logic [15:0]  attack_gain;
        logic [15:0]  release_gain;
        logic [7:0]   delta_thr;
        logic [15:0]  rise_thr;
        logic [15:0]  level_floor;
        logic [2:0]   refractory;
        t_band_result expected_q [$];
        int           mismatches;

        function new();
            active_bands = bepd_pkg::RST_ACTIVE_BANDS;
            amp_gain     = bepd_pkg::RST_AMP_GAIN;
            attack_gain  = bepd_pkg::RST_ATTACK_GAIN;
            release_gain = bepd_pkg::RST_RELEASE_GAIN;
            delta_thr    = bepd_pkg::RST_DELTA_THRESHOLD;
            rise_thr     = bepd_pkg::RST_RISE_THRESHOLD;
            level_floor  = bepd_pkg::RST_LEVEL_FLOOR;
            refractory   = bepd_pkg::RST_REFRACTORY;
            mismatches   = 0;
            clear_bands();
        endfunction

        function void clear_bands();
            foreach (energy_mem[i]) begin
                energy_mem[i] = '0;
                cool_mem[i]   = '0;
            end
        endfunction

        function void write_reg(bepd_pkg::t_cfg_idx idx, logic [15:0] data);
            case (idx)
                bepd_pkg::CFG_ACTIVE_BANDS:    active_bands = data[3:0];
                bepd_pkg::CFG_AMP_GAIN:        amp_gain     = data;
                bepd_pkg::CFG_ATTACK_GAIN:     attack_gain  = data;
                bepd_pkg::CFG_RELEASE_GAIN:    release_gain = data;
                bepd_pkg::CFG_DELTA_THRESHOLD: delta_thr    = data[7:0];
                bepd_pkg::CFG_RISE_THRESHOLD:  rise_thr     = data;
                bepd_pkg::CFG_LEVEL_FLOOR:     level_floor  = data;
                bepd_pkg::CFG_REFRACTORY:      refractory   = data[2:0];
                default: ;
            endcase
        endfunction

        function void note_input(logic restart, logic [3:0] band, logic [15:0] amp,
                                 logic [7:0] delta, logic fresh);
            logic [31:0]  target;
            logic [31:0]  prev;
            logic [31:0]  e;
            logic [31:0]  step;
            logic [31:0]  dark;
            logic [31:0]  sh;
            logic [3:0]   bands;
            logic [2:0]   cd;
            logic         cond;
            t_band_result r;

            if (restart)
                clear_bands();
            r.band = band;
            if (band >= N_BANDS) begin
                // no such band: state untouched, fixed result
                r.energy = '0;
                r.peak   = 1'b0;
                r.shade  = bepd_pkg::SHADE_BASE;
            end else begin
                bands = (active_bands == 0) ? 4'(N_BANDS) : active_bands;
                if (band >= bands)
                    amp = '0;
                target = ({16'd0, amp} * {16'd0, amp_gain}) >> 8;
                if (target > 32'd65535)
                    target = 32'd65535;
                prev = {16'd0, energy_mem[band]};
                if (target > prev) begin
                    step = ((target - prev) * attack_gain) >> 16;
                    e    = prev + step;
                end else begin
                    step = ((prev - target) * release_gain) >> 16;
                    e    = prev - step;
                end
                energy_mem[band] = e[15:0];

                cd = cool_mem[band];
                if (cd != 0)
                    cd = cd - 3'd1;
                if (fresh)
                    cond = delta > delta_thr;
                else
                    cond = (e > prev) && ((e - prev) > rise_thr) && (e > level_floor);
                r.peak = cond && (cd == 0);
                if (r.peak)
                    cd = refractory;
                cool_mem[band] = cd;

                r.energy = e[15:0];
                dark = (e * bepd_pkg::SHADE_MULT) >> 16;
                sh   = (dark >= bepd_pkg::DARK_LIMIT) ? 32'(bepd_pkg::SHADE_MIN)
                                                      : 32'(bepd_pkg::SHADE_BASE) - dark;
                if (sh < bepd_pkg::SHADE_MIN) sh = bepd_pkg::SHADE_MIN;
                if (sh > bepd_pkg::SHADE_MAX) sh = bepd_pkg::SHADE_MAX;
                r.shade = sh[7:0];
            end
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t ns: %s", $time, what);
            mismatches++;
        endtask

        task check_result(t_band_result got);
            t_band_result want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat, band %0d", got.band));
                return;
            end
            want = expected_q.pop_front();
            if (got.band != want.band)
                report_mismatch($sformatf("band_out %0d, want %0d", got.band, want.band));
            if (got.energy != want.energy)
                report_mismatch($sformatf("band %0d energy %0d, want %0d",
                                          want.band, got.energy, want.energy));
            if (got.peak != want.peak)
                report_mismatch($sformatf("band %0d peak %0b, want %0b",
                                          want.band, got.peak, want.peak));
            if (got.shade != want.shade)
                report_mismatch($sformatf("band %0d shade %0d, want %0d",
                                          want.band, got.shade, want.shade));
        endtask
    endclass

    // -----------------------------------------------------------------------
    // DUT signals, inputs all known from time zero
    // -----------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata   = '0;   // [3:0] band, [19:4] amplitude, [27:20] delta
    logic [1:0]  i_s_tuser   = '0;   // [0] restart, [1] delta_fresh
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [31:0] o_m_tdata;          // [3:0] band, [19:4] energy, [27:20] shade
    logic [0:0]  o_m_tuser;          // [0] peak
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;

    band_scoreboard sb;

    int send_idle_pct = 30;      // used by the stimulus process only
    int recv_idle_pct = 82;
    int hold_req      = 0;       // bumped by stimulus to request a long stall
    int hold_seen     = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    band_envelope_peak_detector_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // -----------------------------------------------------------------------
    // Result-side ready: random idling, or a long hold-off when requested
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen  <= hold_req;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // -----------------------------------------------------------------------
    // Monitor. Everything is driven at the rising edge, so the values seen at
    // the falling edge are exactly what the core samples at the next rise.
    // -----------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ((i_cfg_valid && o_cfg_ready) || (i_s_tvalid && o_s_tready) ||
                (o_m_tvalid && i_m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(bepd_pkg::t_cfg_idx'(i_cfg_index), i_cfg_data);
            if (o_m_tvalid && i_m_tready)
                sb.check_result({o_m_tdata[3:0], o_m_tdata[19:4], o_m_tuser[0],
                                 o_m_tdata[27:20]});
            if (i_s_tvalid && o_s_tready)
                sb.note_input(i_s_tuser[0], i_s_tdata[3:0], i_s_tdata[19:4],
                              i_s_tdata[27:20], i_s_tuser[1]);
        end
    end

    // -----------------------------------------------------------------------
    // Drivers. Each task is entered right after a rising edge and returns
    // right after the edge that took its beat; valid stays high between
    // back-to-back beats.
    // -----------------------------------------------------------------------
    task automatic send_band(input logic restart, input logic [3:0] band,
                             input logic [15:0] amp, input logic [7:0] delta,
                             input logic fresh);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'd0, delta, amp, band};
        i_s_tuser  <= {fresh, restart};
        @(negedge i_clk);
        while (!o_s_tready)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // stop sending and sit until every expected beat has come back
    task automatic wait_results_done();
        i_s_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.expected_q.size() != 0);
    endtask

    // core is idle here: write all eight registers back to back
    task automatic apply_settings(input logic [15:0] regs [8]);
        for (int i = 0; i < 8; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_data  <= regs[i];
            @(negedge i_clk);
            while (!o_cfg_ready)
                @(negedge i_clk);
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_stimulus();
        logic [15:0] regs [8];
        logic        rst_bit;
        logic [3:0]  band;
        logic [15:0] amp;

        // directed part, reset register values
        send_band(1'b1, 4'd0, 16'hFFFF, 8'd255, 1'b1);          // fresh delta peak
        repeat (5) send_band(1'b0, 4'd0, 16'hFFFF, 8'd255, 1'b1); // countdown, then fires
        send_band(1'b0, 4'd1, 16'hFFFF, 8'd0, 1'b0);            // local peak on rise
        send_band(1'b0, 4'd1, 16'h0000, 8'd0, 1'b0);            // release
        send_band(1'b0, 4'd3, 16'h1234, 8'd38, 1'b1);           // delta at threshold
        send_band(1'b0, 4'd4, 16'h4321, 8'd39, 1'b1);           // just above
        send_band(1'b0, 4'd11, 16'h0100, 8'd1, 1'b0);           // last band, unit amp
        send_band(1'b0, 4'd12, 16'hFFFF, 8'd255, 1'b1);         // no such band
        send_band(1'b1, 4'd15, 16'hFFFF, 8'd255, 1'b1);         // restart on bad band
        send_band(1'b0, 4'd1, 16'h0000, 8'd0, 1'b0);            // cleared energy
        send_band(1'b0, 4'd5, 16'h0001, 8'd0, 1'b0);
        send_band(1'b0, 4'd6, 16'h8000, 8'h80, 1'b0);
        send_band(1'b0, 4'd14, 16'h5555, 8'h55, 1'b0);
        send_band(1'b0, 4'd13, 16'hAAAA, 8'hAA, 1'b1);
        send_band(1'b0, 4'd1, 16'hFFFF, 8'd0, 1'b0);
        wait_results_done();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph == 0) begin
                foreach (regs[i]) regs[i] = '0;
            end else if (ph == 1) begin
                regs[bepd_pkg::CFG_ACTIVE_BANDS]    = 16'd15;
                regs[bepd_pkg::CFG_AMP_GAIN]        = 16'hFFFF;
                regs[bepd_pkg::CFG_ATTACK_GAIN]     = 16'hFFFF;
                regs[bepd_pkg::CFG_RELEASE_GAIN]    = 16'hFFFF;
                regs[bepd_pkg::CFG_DELTA_THRESHOLD] = 16'd255;
                regs[bepd_pkg::CFG_RISE_THRESHOLD]  = 16'hFFFF;
                regs[bepd_pkg::CFG_LEVEL_FLOOR]     = 16'hFFFF;
                regs[bepd_pkg::CFG_REFRACTORY]      = 16'd7;
            end else begin
                // thresholds kept low enough that local peaks still happen
                regs[bepd_pkg::CFG_ACTIVE_BANDS]    = 16'($urandom_range(15));
                regs[bepd_pkg::CFG_AMP_GAIN]        = 16'($urandom_range(65535));
                regs[bepd_pkg::CFG_ATTACK_GAIN]     = 16'($urandom_range(65535));
                regs[bepd_pkg::CFG_RELEASE_GAIN]    = 16'($urandom_range(65535));
                regs[bepd_pkg::CFG_DELTA_THRESHOLD] = 16'($urandom_range(255));
                regs[bepd_pkg::CFG_RISE_THRESHOLD]  = 16'($urandom_range(12000));
                regs[bepd_pkg::CFG_LEVEL_FLOOR]     = 16'($urandom_range(30000));
                regs[bepd_pkg::CFG_REFRACTORY]      = 16'($urandom_range(7));
            end
            apply_settings(regs);

            // idling: sender light / receiver heavy, then swapped, then none
            send_idle_pct = (ph < 2) ? 30 : (ph < 4) ? 82 : 0;
            recv_idle_pct <= (ph < 2) ? 82 : (ph < 4) ? 30 : 0;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == 10)
                    hold_req <= hold_req + 1;      // core backs up behind m side
                if (ph == 3 && n == 50)
                    wait_results_done();           // sender drains completely
                rst_bit = ($urandom_range(99) < 3);
                band = ($urandom_range(99) < 6) ? 4'($urandom_range(15, 12))
                                                : 4'($urandom_range(11));
                case ($urandom_range(3))
                    0: amp = 16'h0000;
                    1: amp = 16'hFFFF;
                    2: amp = 16'($urandom_range(1023));
                    default: amp = 16'($urandom_range(65535));
                endcase
                send_band(rst_bit, band, amp, 8'($urandom_range(255)),
                          1'($urandom_range(1)));
            end
            wait_results_done();
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // -----------------------------------------------------------------------
    // Main: reset once, run, watchdog in parallel
    // -----------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            run_stimulus();
            wait (idle_cycles >= STALL_LIMIT);
        join_any
        if (idle_cycles < STALL_LIMIT && sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
